// ===== src/escape_sequence_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// Escape sequence decoder assertion macros
// Shared helpers for concurrent checks clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_SEQUENCE_DECODER_DEFINES_SVH
`define ESCAPE_SEQUENCE_DECODER_DEFINES_SVH

// same-cycle implication
`define ESD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ESD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/esd_pkg.sv =====
// ----------------------------------------------------------------------------
// Escape sequence decoder package
// Types, character codes and small lookup functions shared by the block.
// ----------------------------------------------------------------------------
package esd_pkg;

  // escape parser phase
  typedef enum logic [1:0] {
    PH_TEXT = 2'd0,
    PH_ESC  = 2'd1,
    PH_HEX  = 2'd2
  } esd_phase_t;

  // configuration register indexes
  localparam logic [1:0] CFG_CTRL_ENABLE    = 2'd0;
  localparam logic [1:0] CFG_UNICODE_ENABLE = 2'd1;
  localparam logic [1:0] CFG_DROP_BACKSLASH = 2'd2;

  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_QMARK     = 8'h3f;
  localparam logic [7:0] CH_U_LOWER   = 8'h75;
  localparam logic [7:0] CH_U_UPPER   = 8'h55;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_A_LOWER   = 8'h61;
  localparam logic [7:0] CH_F_LOWER   = 8'h66;
  localparam logic [7:0] CASE_BIT     = 8'h20;
  localparam logic [7:0] HEX_ALPHA_BIAS = 8'h57;  // 'W': 'a' - 10

  localparam logic [4:0] HEX_BAD = 5'd16;

  localparam logic [3:0] DIGITS_SHORT = 4'd4;
  localparam logic [3:0] DIGITS_LONG  = 4'd8;

  localparam logic [7:0] UTF8_LEAD2 = 8'hc0;
  localparam logic [7:0] UTF8_LEAD3 = 8'he0;
  localparam logic [7:0] UTF8_LEAD4 = 8'hf0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;

  localparam int CP_BITS = 21;   // code points below 2^21 are encodable
  localparam int MAX_OUT = 4;

  typedef struct packed {
    logic ctrl_enable;
    logic unicode_enable;
    logic drop_backslash;
  } esd_cfg_t;

  // bytes produced by one input request
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] bytes;
    logic [2:0]              cnt;
    logic                    eos;
  } esd_grp_t;

  // returns HEX_BAD for a byte that is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] lc;
    logic [7:0] d;
    lc = c | CASE_BIT;
    d  = lc - HEX_ALPHA_BIAS;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      return {1'b0, c[3:0]};
    end else if (lc >= CH_A_LOWER && lc <= CH_F_LOWER) begin
      return {1'b0, d[3:0]};
    end
    return HEX_BAD;
  endfunction

  // control byte for an escape letter, zero when not a control letter
  function automatic logic [7:0] ctrl_code(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      8'h74:   r = 8'h09;  // t
      8'h6e:   r = 8'h0a;  // n
      8'h72:   r = 8'h0d;  // r
      8'h66:   r = 8'h0c;  // f
      8'h61:   r = 8'h07;  // a
      8'h62:   r = 8'h08;  // b
      8'h76:   r = 8'h0b;  // v
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== src/esd_decode.sv =====
// ----------------------------------------------------------------------------
// Escape sequence decoder: escape parser
// Holds the escape state and turns one input byte into up to four output
// bytes combinationally.
// ----------------------------------------------------------------------------
module esd_decode
  import esd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] in_b,
  input  logic       in_eos,
  input  esd_cfg_t   cfg,
  output esd_grp_t   grp
);

  esd_phase_t           phase_r, phase_nxt, phase_step;
  logic [3:0]           digits_r, digits_nxt;
  logic [CP_BITS-1:0]   cp_r, cp_nxt, cp_sh;
  logic                 ovf_r, ovf_nxt, ovf_sh;

  logic [4:0]           hv;
  logic [7:0]           cc;
  logic                 is_ctrl;
  logic                 is_hex_esc;
  logic                 hex_last;

  assign hv         = hex_value(in_b);
  assign cc         = ctrl_code(in_b);
  assign is_ctrl    = (cc != 8'h00);
  assign is_hex_esc = (in_b == CH_U_LOWER) || (in_b == CH_U_UPPER);
  assign hex_last   = (digits_r <= 4'd1);

  // accumulator keeps the low bits plus a sticky flag for >= 2^21 or a bad digit
  assign cp_sh  = {cp_r[CP_BITS-5:0], hv[3:0]};
  assign ovf_sh = ovf_r | hv[4] | (cp_r[CP_BITS-1:CP_BITS-4] != 4'd0);

  // next state
  always_comb begin
    phase_step = phase_r;
    digits_nxt = digits_r;
    cp_nxt     = cp_r;
    ovf_nxt    = ovf_r;
    unique case (phase_r)
      PH_ESC: begin
        phase_step = PH_TEXT;
        if (!(is_ctrl && cfg.ctrl_enable) && is_hex_esc && cfg.unicode_enable) begin
          phase_step = PH_HEX;
          digits_nxt = (in_b == CH_U_UPPER) ? DIGITS_LONG : DIGITS_SHORT;
          cp_nxt     = '0;
          ovf_nxt    = 1'b0;
        end
      end
      PH_HEX: begin
        cp_nxt  = cp_sh;
        ovf_nxt = ovf_sh;
        if (hex_last) begin
          phase_step = PH_TEXT;
          digits_nxt = 4'd0;
        end else begin
          digits_nxt = digits_r - 4'd1;
        end
      end
      default: begin
        if (in_b == CH_BACKSLASH) begin
          phase_step = PH_ESC;
        end
      end
    endcase
    phase_nxt = phase_step;
    if (in_eos) begin
      phase_nxt  = PH_TEXT;
      digits_nxt = 4'd0;
      cp_nxt     = '0;
      ovf_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TEXT;
      digits_r <= 4'd0;
      cp_r     <= '0;
      ovf_r    <= 1'b0;
    end else if (acc) begin
      phase_r  <= phase_nxt;
      digits_r <= digits_nxt;
      cp_r     <= cp_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  // output bytes
  always_comb begin
    logic [MAX_OUT-1:0][7:0] b;
    logic [2:0]              n;
    b = '0;
    n = 3'd0;
    unique case (phase_r)
      PH_ESC: begin
        if (is_ctrl && cfg.ctrl_enable) begin
          b[n[1:0]] = cc;           n = n + 3'd1;
        end else if (is_hex_esc && cfg.unicode_enable) begin
          n = 3'd0;
        end else if (is_ctrl || is_hex_esc) begin
          b[n[1:0]] = CH_BACKSLASH; n = n + 3'd1;
          b[n[1:0]] = in_b;         n = n + 3'd1;
        end else begin
          if (!cfg.drop_backslash) begin
            b[n[1:0]] = CH_BACKSLASH; n = n + 3'd1;
          end
          b[n[1:0]] = in_b;         n = n + 3'd1;
        end
      end
      PH_HEX: begin
        if (hex_last) begin
          if (ovf_sh) begin
            b[0] = CH_QMARK;
            n    = 3'd1;
          end else if (cp_sh[CP_BITS-1:7] == '0) begin
            b[0] = {1'b0, cp_sh[6:0]};
            n    = 3'd1;
          end else if (cp_sh[CP_BITS-1:11] == '0) begin
            b[0] = UTF8_LEAD2 | {3'b000, cp_sh[10:6]};
            b[1] = UTF8_CONT  | {2'b00, cp_sh[5:0]};
            n    = 3'd2;
          end else if (cp_sh[CP_BITS-1:16] == '0) begin
            b[0] = UTF8_LEAD3 | {4'b0000, cp_sh[15:12]};
            b[1] = UTF8_CONT  | {2'b00, cp_sh[11:6]};
            b[2] = UTF8_CONT  | {2'b00, cp_sh[5:0]};
            n    = 3'd3;
          end else begin
            b[0] = UTF8_LEAD4 | {5'b00000, cp_sh[20:18]};
            b[1] = UTF8_CONT  | {2'b00, cp_sh[17:12]};
            b[2] = UTF8_CONT  | {2'b00, cp_sh[11:6]};
            b[3] = UTF8_CONT  | {2'b00, cp_sh[5:0]};
            n    = 3'd4;
          end
        end
      end
      default: begin
        if (in_b != CH_BACKSLASH) begin
          b[0] = in_b;
          n    = 3'd1;
        end
      end
    endcase
    // string end flushes a dangling escape
    if (in_eos) begin
      if (phase_step == PH_ESC) begin
        b[n[1:0]] = CH_BACKSLASH; n = n + 3'd1;
      end else if (phase_step == PH_HEX) begin
        b[n[1:0]] = CH_QMARK;     n = n + 3'd1;
      end
    end
    grp.bytes = b;
    grp.cnt   = n;
    grp.eos   = in_eos;
  end

endmodule

// ===== src/escape_sequence_decoder.sv =====
// ----------------------------------------------------------------------------
// Escape sequence decoder
// Resolves backslash escapes in a byte stream, with UTF-8 output for
// \u and \U hex escapes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one raw byte per request plus
//   in_end_of_string on the final byte of a string. Output channel
//   (out_valid/out_stall) carries one decoded byte per request, with
//   out_last_of_run on the last byte caused by an input byte and
//   out_string_done on the last byte of the string.
//   An input byte is decoded in the cycle it is accepted; its 0 to 4 bytes
//   appear at the output from the next cycle, one per cycle while not stalled.
//   Throughput is one input byte per cycle while each byte yields at most
//   one output byte and out_stall is low; a byte yielding more holds the
//   input until its last byte leaves the single output byte lane. Bytes
//   opening or continuing an escape yield nothing and never hold the input.
//   When the receiver stalls, the pending byte holds and the input stalls
//   once the result register has no room for the next group.
//   Reset (rst_n low, synchronous) empties the output and returns to plain
//   text; all three configuration bits reset to 1. Write configuration via
//   cfg_we/cfg_index/cfg_data only while idle.
// ----------------------------------------------------------------------------
`include "escape_sequence_decoder_defines.svh"

module escape_sequence_decoder
  import esd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,

  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic       cfg_data,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_string,

  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  output logic       out_string_done
);

  esd_cfg_t   cfg_r;
  esd_grp_t   grp_dec;
  esd_grp_t   grp_r;
  logic       grp_vld_r;
  logic [1:0] idx_r;

  logic       in_acc;
  logic       out_take;
  logic       out_last;
  logic       drain_last;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{ctrl_enable: 1'b1, unicode_enable: 1'b1, drop_backslash: 1'b1};
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CTRL_ENABLE:    cfg_r.ctrl_enable    <= cfg_data;
        CFG_UNICODE_ENABLE: cfg_r.unicode_enable <= cfg_data;
        CFG_DROP_BACKSLASH: cfg_r.drop_backslash <= cfg_data;
        default: ;
      endcase
    end
  end

  esd_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (in_acc),
    .in_b   (in_byte),
    .in_eos (in_end_of_string),
    .cfg    (cfg_r),
    .grp    (grp_dec)
  );

  assign out_last   = ({1'b0, idx_r} == (grp_r.cnt - 3'd1));
  assign out_take   = out_valid && !out_stall;
  assign drain_last = out_take && out_last;

  // a new group may load in the cycle the last pending byte leaves
  assign in_stall = grp_vld_r && !drain_last;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_vld_r <= 1'b0;
      idx_r     <= 2'd0;
    end else if (in_acc && grp_dec.cnt != 3'd0) begin
      grp_vld_r <= 1'b1;
      idx_r     <= 2'd0;
    end else if (drain_last) begin
      grp_vld_r <= 1'b0;
      idx_r     <= 2'd0;
    end else if (out_take) begin
      idx_r     <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && grp_dec.cnt != 3'd0) begin
      grp_r <= grp_dec;
    end
  end

  assign out_valid       = grp_vld_r;
  assign out_byte        = grp_r.bytes[idx_r];
  assign out_last_of_run = out_last;
  assign out_string_done = out_last && grp_r.eos;

  `ESD_ASSERT_IMP(a_grp_count, grp_vld_r, (grp_r.cnt != 3'd0) && ({1'b0, idx_r} < grp_r.cnt), "pending group count out of range")
  `ESD_ASSERT_NXT(a_eos_yields, in_acc && in_end_of_string, grp_vld_r && grp_r.eos, "final byte of string gave no result")
  `ESD_ASSERT_NXT(a_idx_step, out_take && !out_last, grp_vld_r && (idx_r == $past(idx_r) + 2'd1), "byte index did not advance")

endmodule

// ===== tb/sv/tb_escape_sequence_decoder.sv =====
// ----------------------------------------------------------------------------
// Escape sequence decoder testbench
// Drives the decoder first from a short directed table and then from random
// strings built mostly of well-formed escapes. It runs under every setting
// of the three enable bits. A local model predicts each decoded byte, with
// its end-of-run and end-of-string flags. Both channels idle at random, and
// one long output hold-off lets the block fill up and stall its input.
// ----------------------------------------------------------------------------
module tb_escape_sequence_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import esd_pkg::*;

  localparam int IDLE_LIMIT  = 2000;  // cycles with no request accepted
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;
  localparam int PHASE_ITEMS = 25;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
  } decoded_rec_t;

  // n_fixed != 0: the row carries its own expected bytes, MSB byte first
  typedef struct packed {
    logic       is_cfg;
    esd_cfg_t   cfg;
    logic [7:0] data;
    logic       eos;
    logic [2:0] n_fixed;
    logic [31:0] fixed_bytes;
  } dir_row_t;

  localparam int DIR_ROWS = 28;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{1'b0, 3'b111, 8'h00, 1'b0, 3'd1, 32'h0000_0000},  // lowest byte
    '{1'b0, 3'b111, 8'hff, 1'b1, 3'd1, 32'hff00_0000},  // highest byte, ends string
    '{1'b0, 3'b111, 8'h5c, 1'b0, 3'd0, 32'h0},
    '{1'b0, 3'b111, 8'h6e, 1'b0, 3'd1, 32'h0a00_0000},  // \n
    '{1'b0, 3'b111, 8'h5c, 1'b0, 3'd0, 32'h0},          // \ud800, surrogate
    '{1'b0, 3'b111, 8'h75, 1'b0, 3'd0, 32'h0},
    '{1'b0, 3'b111, 8'h64, 1'b0, 3'd0, 32'h0},
    '{1'b0, 3'b111, 8'h38, 1'b0, 3'd0, 32'h0},
    '{1'b0, 3'b111, 8'h30, 1'b0, 3'd0, 32'h0},
    '{1'b0, 3'b111, 8'h30, 1'b0, 3'd0, 32'h0},
    '{1'b0, 3'b111, 8'h5c, 1'b0, 3'd0, 32'h0},          // \ug123, bad digit
    '{1'b0, 3'b111, 8'h75, 1'b0, 3'd0, 32'h0},
    '{1'b0, 3'b111, 8'h67, 1'b0, 3'd0, 32'h0},
    '{1'b0, 3'b111, 8'h31, 1'b0, 3'd0, 32'h0},
    '{1'b0, 3'b111, 8'h32, 1'b0, 3'd0, 32'h0},
    '{1'b0, 3'b111, 8'h33, 1'b0, 3'd1, 32'h3f00_0000},
    '{1'b0, 3'b111, 8'h5c, 1'b1, 3'd1, 32'h5c00_0000},  // trailing lone backslash
    '{1'b0, 3'b111, 8'h5c, 1'b0, 3'd0, 32'h0},          // \U0 cut by end of string
    '{1'b0, 3'b111, 8'h55, 1'b0, 3'd0, 32'h0},
    '{1'b0, 3'b111, 8'h30, 1'b1, 3'd1, 32'h3f00_0000},
    '{1'b1, 3'b000, 8'h00, 1'b0, 3'd0, 32'h0},          // everything off
    '{1'b0, 3'b000, 8'h5c, 1'b0, 3'd0, 32'h0},
    '{1'b0, 3'b000, 8'h74, 1'b0, 3'd2, 32'h5c74_0000},  // \t kept as is
    '{1'b0, 3'b000, 8'h5c, 1'b0, 3'd0, 32'h0},
    '{1'b0, 3'b000, 8'h55, 1'b0, 3'd2, 32'h5c55_0000},  // \U kept as is
    '{1'b0, 3'b000, 8'h5c, 1'b0, 3'd0, 32'h0},
    '{1'b0, 3'b000, 8'h71, 1'b1, 3'd2, 32'h5c71_0000},  // backslash not dropped
    '{1'b1, 3'b111, 8'h00, 1'b0, 3'd0, 32'h0}
  };

  // {ctrl, unicode, drop} per random phase
  localparam esd_cfg_t PHASE_CFGS [8] = '{
    3'b111, 3'b000, 3'b101, 3'b010, 3'b011, 3'b100, 3'b110, 3'b001
  };

  localparam logic [7:0] CTRL_LETTERS [7] = '{
    8'h74, 8'h6e, 8'h72, 8'h66, 8'h61, 8'h62, 8'h76
  };

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic       cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_end_of_string;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_last_of_run;
  logic       out_string_done;

  // decoder model state
  esd_cfg_t    cfg_model;
  esd_phase_t  scan_phase;
  logic [3:0]  digits_left;
  logic [31:0] code_acc;
  logic [7:0]  decoded [4];
  int          decoded_n;

  decoded_rec_t pending_bytes [$];
  int          typed_n;
  logic [31:0] typed_bytes;
  int          errors;
  int          idle_cycles;
  int          items_sent;
  int          send_burst;
  bit          hold_req;
  bit          hold_done;

  escape_sequence_decoder uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last_of_run  (out_last_of_run),
    .out_string_done  (out_string_done)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic logic [4:0] hex_digit_val(input logic [7:0] c);
    logic [7:0] folded;
    folded = c | 8'h20;
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if (folded >= 8'h61 && folded <= 8'h66) return {1'b0, folded[3:0] + 4'd9};
    return 5'h10;
  endfunction

  function automatic logic [7:0] ctrl_byte_for(input logic [7:0] c);
    case (c)
      8'h74:   return 8'h09;
      8'h6e:   return 8'h0a;
      8'h72:   return 8'h0d;
      8'h66:   return 8'h0c;
      8'h61:   return 8'h07;
      8'h62:   return 8'h08;
      8'h76:   return 8'h0b;
      default: return 8'h00;
    endcase
  endfunction

  function void emit(input logic [7:0] v);
    decoded[decoded_n] = v;
    decoded_n++;
  endfunction

  function void emit_utf8(input logic [31:0] x);
    if (x < 32'h80) begin
      emit(x[7:0]);
    end else if (x < 32'h800) begin
      emit(UTF8_LEAD2 | {3'b0, x[10:6]});
      emit(UTF8_CONT | {2'b0, x[5:0]});
    end else if (x < 32'h1_0000) begin
      emit(UTF8_LEAD3 | {4'b0, x[15:12]});
      emit(UTF8_CONT | {2'b0, x[11:6]});
      emit(UTF8_CONT | {2'b0, x[5:0]});
    end else if (x < (32'd1 << CP_BITS)) begin
      emit(UTF8_LEAD4 | {5'b0, x[20:18]});
      emit(UTF8_CONT | {2'b0, x[17:12]});
      emit(UTF8_CONT | {2'b0, x[11:6]});
      emit(UTF8_CONT | {2'b0, x[5:0]});
    end else begin
      emit(CH_QMARK);
    end
  endfunction

  // advances the model by one input byte; results land in decoded[]
  function void decode_byte(input logic [7:0] b, input logic eos);
    logic [7:0] cc;
    logic [4:0] d;
    logic       hex_esc;
    decoded_n = 0;
    case (scan_phase)
      PH_ESC: begin
        cc = ctrl_byte_for(b);
        hex_esc = (b == CH_U_LOWER) || (b == CH_U_UPPER);
        scan_phase = PH_TEXT;
        if (cc != 8'h00 && cfg_model.ctrl_enable) begin
          emit(cc);
        end else if (hex_esc && cfg_model.unicode_enable) begin
          scan_phase = PH_HEX;
          digits_left = (b == CH_U_UPPER) ? DIGITS_LONG : DIGITS_SHORT;
          code_acc = '0;
        end else if (cc != 8'h00 || hex_esc) begin
          emit(CH_BACKSLASH);
          emit(b);
        end else begin
          if (!cfg_model.drop_backslash) emit(CH_BACKSLASH);
          emit(b);
        end
      end
      PH_HEX: begin
        d = hex_digit_val(b);
        code_acc = d[4] ? 32'hffff_ffff : {code_acc[27:0], d[3:0]};
        if (digits_left <= 4'd1) begin
          digits_left = '0;
          scan_phase = PH_TEXT;
          emit_utf8(code_acc);
        end else begin
          digits_left = digits_left - 4'd1;
        end
      end
      default: begin
        if (b == CH_BACKSLASH) scan_phase = PH_ESC;
        else emit(b);
      end
    endcase
    if (eos) begin
      if (scan_phase == PH_ESC) emit(CH_BACKSLASH);
      else if (scan_phase == PH_HEX) emit(CH_QMARK);
      scan_phase = PH_TEXT;
      digits_left = '0;
      code_acc = '0;
    end
  endfunction

  function automatic int draw_wait(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(8, 30);
    return $urandom_range(0, 17);
  endfunction

  // mostly valid digits in either case, now and then a stray byte
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
    if (nib < 4'd10) return 8'h30 + 8'(nib);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
  endfunction

  task automatic send_request(input logic [7:0] b, input logic eos,
                              input int fixed_n = 0, input logic [31:0] fixed_bytes = '0);
    int gap;
    gap = draw_wait(send_burst);
    @(negedge clk);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_end_of_string <= eos;
    typed_n = fixed_n;
    typed_bytes = fixed_bytes;
    do @(posedge clk); while (!(in_valid && !in_stall));
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic apply_cfg(input esd_cfg_t c);
    put_reg(CFG_CTRL_ENABLE, c.ctrl_enable);
    put_reg(CFG_UNICODE_ENABLE, c.unicode_enable);
    put_reg(CFG_DROP_BACKSLASH, c.drop_backslash);
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_model = c;
  endtask

  // one string of 1..6 tokens, end-of-string on its last byte
  task automatic send_string();
    int ntok;
    int kind;
    int ndig;
    int range_sel;
    logic [31:0] cp;
    logic [7:0] tok [$];
    logic stop;
    ntok = $urandom_range(1, 6);
    stop = 1'b0;
    for (int t = 0; t < ntok && !stop; t++) begin
      tok.delete();
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1: tok.push_back(8'($urandom_range(0, 255)));
        2, 3: begin
          tok.push_back(CH_BACKSLASH);
          tok.push_back(CTRL_LETTERS[$urandom_range(0, 6)]);
        end
        4: begin
          tok.push_back(CH_BACKSLASH);
          tok.push_back(8'($urandom_range(0, 255)));
        end
        5, 6, 7, 8: begin
          ndig = (kind < 7) ? 4 : 8;
          range_sel = $urandom_range(0, (ndig == 4) ? 2 : 4);
          case (range_sel)
            0:       cp = $urandom_range(0, 'h7f);
            1:       cp = $urandom_range('h80, 'h7ff);
            2:       cp = $urandom_range('h800, 'hffff);
            3:       cp = $urandom_range('h1_0000, 'h1f_ffff);
            default: cp = $urandom_range('h20_0000, 'hffff_ffff);
          endcase
          tok.push_back(CH_BACKSLASH);
          tok.push_back((ndig == 4) ? CH_U_LOWER : CH_U_UPPER);
          for (int i = ndig - 1; i >= 0; i--) tok.push_back(hex_char(cp[4*i +: 4]));
        end
        default: begin
          // escape cut short by the end of the string
          tok.push_back(CH_BACKSLASH);
          if ($urandom_range(0, 3) != 0) begin
            tok.push_back($urandom_range(0, 1) ? CH_U_LOWER : CH_U_UPPER);
            repeat ($urandom_range(0, 3)) tok.push_back(hex_char(4'($urandom)));
          end
          stop = 1'b1;
        end
      endcase
      for (int i = 0; i < tok.size(); i++)
        send_request(tok[i], (stop || t == ntok - 1) && i == tok.size() - 1);
    end
  endtask

  // scoreboard: predict on accepted input request, check on accepted output
  always @(posedge clk) begin : monitor
    decoded_rec_t rec;
    logic in_acc;
    logic out_acc;
    if (rst_n) begin
      in_acc = in_valid && !in_stall;
      out_acc = out_valid && !out_stall;
      if (in_acc) begin
        decode_byte(in_byte, in_end_of_string);
        if (typed_n != 0) begin
          decoded_n = typed_n;
          for (int k = 0; k < typed_n; k++) decoded[k] = typed_bytes[31 - 8*k -: 8];
        end
        for (int k = 0; k < decoded_n; k++) begin
          rec.data = decoded[k];
          rec.last = (k == decoded_n - 1);
          rec.done = rec.last && in_end_of_string;
          pending_bytes.push_back(rec);
        end
      end
      if (out_acc) begin
        if (pending_bytes.size() == 0) begin
          $display("%0t: unexpected output byte %h", $time, out_byte);
          errors++;
        end else begin
          rec = pending_bytes.pop_front();
          if (out_byte !== rec.data) begin
            $display("%0t: out_byte expected %h got %h", $time, rec.data, out_byte);
            errors++;
          end
          if (out_last_of_run !== rec.last) begin
            $display("%0t: out_last_of_run expected %b got %b", $time, rec.last,
                     out_last_of_run);
            errors++;
          end
          if (out_string_done !== rec.done) begin
            $display("%0t: out_string_done expected %b got %b", $time, rec.done,
                     out_string_done);
            errors++;
          end
        end
      end
      idle_cycles = (in_acc || out_acc) ? 0 : idle_cycles + 1;
    end
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("%0t: no request accepted for %0d cycles", $time, IDLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : receiver
    int wait_n;
    int burst_left;
    out_stall = 1'b0;
    burst_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      wait_n = draw_wait(burst_left);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        wait_n = HOLD_CYCLES;
      end
      repeat (wait_n) begin
        out_stall <= 1'b1;
        @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin : stimulus
    int start;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_CTRL_ENABLE;
    cfg_data = 1'b0;
    in_valid = 1'b0;
    in_byte = '0;
    in_end_of_string = 1'b0;
    cfg_model = '1;
    scan_phase = PH_TEXT;
    digits_left = '0;
    code_acc = '0;
    typed_n = 0;
    typed_bytes = '0;
    errors = 0;
    idle_cycles = 0;
    items_sent = 0;
    send_burst = 0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIR_TABLE[i]) begin
      if (DIR_TABLE[i].is_cfg) begin
        wait_idle();
        apply_cfg(DIR_TABLE[i].cfg);
      end else begin
        send_request(DIR_TABLE[i].data, DIR_TABLE[i].eos, int'(DIR_TABLE[i].n_fixed),
                     DIR_TABLE[i].fixed_bytes);
      end
    end

    foreach (PHASE_CFGS[p]) begin
      wait_idle();
      apply_cfg(PHASE_CFGS[p]);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        // long output hold-off while the sender keeps going
        if (p == 2 && items_sent - start >= 8) hold_req = 1'b1;
        send_string();
      end
    end

    wait_idle();
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
